// ===== design/lzwle_pkg.sv =====
`timescale 1ns / 1ps

package lzwle_pkg;

  // Dictionary geometry
  localparam int DICT_SIZE = 128;
  localparam int CODE_W    = $clog2(DICT_SIZE);
  localparam int FREE_W    = CODE_W + 1;
  localparam int LETTER_W  = 5;

  localparam logic [LETTER_W-1:0] LETTER_COUNT = LETTER_W'(26);
  localparam logic [FREE_W-1:0]   FIRST_FREE   = FREE_W'(27);
  localparam logic [FREE_W-1:0]   DICT_TOP     = FREE_W'(DICT_SIZE);

  // One learned entry: prefix code plus extending letter
  typedef struct packed {
    logic [CODE_W-1:0]   pfx;
    logic [LETTER_W-1:0] letter;
  } entry_t;

  // Write request into the dictionary memory
  typedef struct packed {
    logic              en;
    logic [CODE_W-1:0] addr;
    entry_t            data;
  } dict_wr_t;

  // Read request into the dictionary memory
  typedef struct packed {
    logic              en;
    logic [CODE_W-1:0] addr;
  } dict_rd_t;

  // One emitted item
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } result_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

endpackage

// ===== design/lzwle_if.sv =====
`timescale 1ns / 1ps

// Letter channel
interface lzwle_in_if;
  logic                            valid;
  logic                            ready;
  logic [lzwle_pkg::LETTER_W-1:0]  letter;
  logic                            end_of_text;

  modport source (output valid, output letter, output end_of_text, input ready);
  modport sink   (input valid, input letter, input end_of_text, output ready);
endinterface

// Code channel
interface lzwle_out_if;
  logic                          valid;
  logic                          ready;
  logic [lzwle_pkg::CODE_W-1:0]  code_out;
  logic                          last_code;

  modport source (output valid, output code_out, output last_code, input ready);
  modport sink   (input valid, input code_out, input last_code, output ready);
endinterface

// ===== design/lzwle_dict.sv =====
`timescale 1ns / 1ps

// Dictionary store: one write port, one registered read port
module lzwle_dict (
  input  logic                clk_i,
  input  lzwle_pkg::dict_wr_t wr_i,
  input  lzwle_pkg::dict_rd_t rd_i,
  output lzwle_pkg::entry_t   rd_data_o
);

  lzwle_pkg::entry_t mem_q [lzwle_pkg::DICT_SIZE];
  lzwle_pkg::entry_t rd_data_q;

  // Store a new entry
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Fetch one entry per cycle
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/lzw_letter_encoder_unit.sv =====
`timescale 1ns / 1ps

// LZW encoder over the letters A to Z (letter 0 = A ... 25 = Z).
// in_i carries one letter per item plus end_of_text on the last letter of a
// message; out_o carries emitted codes, last_code set on the final code.
// Both channels use valid/ready; an item moves when both are high.
// Each letter is matched against the learned entries by a linear search
// through the dictionary memory, one entry per cycle through its single
// registered read port. The search covers the E learned entries, E being
// at most 101, and is skipped with no running prefix or learned entry.
// in_i.ready is high only while the sequencer is idle. Codes are written
// into the output queue as the item finishes. Letters 26 to 31 are
// dropped with no effect. After the final code the dictionary starts over.
// Results wait in a two-item output queue; a stalled receiver only holds
// back a new item once the queue lacks room for its results.
// Reset clears the prefix, the queue and the sequencer; the dictionary
// needs no clearing, as only entries below the fill count are searched.
module lzw_letter_encoder_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  lzwle_in_if.sink     in_i,
  lzwle_out_if.source  out_o
);

  localparam int CW = lzwle_pkg::CODE_W;
  localparam int FW = lzwle_pkg::FREE_W;
  localparam int LW = lzwle_pkg::LETTER_W;

  lzwle_pkg::state_e   state_q, state_d;
  logic [LW-1:0]       sym_q, sym_d;
  logic                eot_q, eot_d;
  logic [CW-1:0]       pfx_q, pfx_d;
  logic                pvalid_q, pvalid_d;
  logic [FW-1:0]       next_free_q, next_free_d;
  logic [FW-1:0]       scan_q, scan_d;
  logic                dvld_q, dvld_d;
  logic                miss_q, miss_d;
  logic [CW-1:0]       npfx_q, npfx_d;

  lzwle_pkg::result_t  slot_q [2];
  logic                wp_q, rp_q;
  logic [1:0]          cnt_q, cnt_d;

  lzwle_pkg::dict_wr_t dict_wr;
  lzwle_pkg::dict_rd_t dict_rd;
  lzwle_pkg::entry_t   rd_data;

  logic                in_acc;
  logic                match;
  logic [FW-1:0]       scan_prev;
  logic [1:0]          need;
  logic                room;
  logic                push;
  logic                pop;
  lzwle_pkg::result_t  res0, res1;

  lzwle_dict u_dict (
    .clk_i     (clk_i),
    .wr_i      (dict_wr),
    .rd_i      (dict_rd),
    .rd_data_o (rd_data)
  );

  assign in_i.ready = (state_q == lzwle_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // Compare the entry fetched last cycle
  assign match     = dvld_q && (rd_data.pfx == pfx_q) && (rd_data.letter == sym_q);
  assign scan_prev = scan_q - FW'(1);

  // Results of the finishing item
  assign need = {1'b0, miss_q} + {1'b0, eot_q};
  assign room = (2'd2 - cnt_q) >= need;
  assign push = (state_q == lzwle_pkg::ST_FINISH) && room;
  assign pop  = out_o.valid && out_o.ready;
  assign res0 = miss_q ? lzwle_pkg::result_t'{code: pfx_q, last: 1'b0}
                       : lzwle_pkg::result_t'{code: npfx_q, last: 1'b1};
  assign res1 = lzwle_pkg::result_t'{code: npfx_q, last: 1'b1};

  // Sequencer
  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    eot_d       = eot_q;
    pfx_d       = pfx_q;
    pvalid_d    = pvalid_q;
    next_free_d = next_free_q;
    scan_d      = scan_q;
    dvld_d      = dvld_q;
    miss_d      = miss_q;
    npfx_d      = npfx_q;
    dict_rd     = '{en: 1'b0, addr: scan_q[CW-1:0]};
    dict_wr     = '{en: 1'b0, addr: next_free_q[CW-1:0],
                    data: '{pfx: pfx_q, letter: sym_q}};
    unique case (state_q)
      lzwle_pkg::ST_IDLE: begin
        if (in_acc && (in_i.letter < lzwle_pkg::LETTER_COUNT)) begin
          sym_d  = in_i.letter;
          eot_d  = in_i.end_of_text;
          npfx_d = CW'(in_i.letter) + CW'(1);
          scan_d = lzwle_pkg::FIRST_FREE;
          dvld_d = 1'b0;
          if (pvalid_q && (next_free_q > lzwle_pkg::FIRST_FREE)) begin
            state_d = lzwle_pkg::ST_SEARCH;
          end else begin
            // no prefix or no learned entry: nothing to search, a prefix cannot extend
            miss_d  = pvalid_q;
            state_d = lzwle_pkg::ST_FINISH;
          end
        end
      end
      lzwle_pkg::ST_SEARCH: begin
        if (match) begin
          miss_d  = 1'b0;
          npfx_d  = scan_prev[CW-1:0];
          state_d = lzwle_pkg::ST_FINISH;
        end else if (scan_q == next_free_q) begin
          miss_d  = 1'b1;
          npfx_d  = CW'(sym_q) + CW'(1);
          state_d = lzwle_pkg::ST_FINISH;
        end else begin
          dict_rd.en = 1'b1;
          scan_d     = scan_q + FW'(1);
          dvld_d     = 1'b1;
        end
      end
      lzwle_pkg::ST_FINISH: begin
        if (room) begin
          if (miss_q && (next_free_q < lzwle_pkg::DICT_TOP)) begin
            dict_wr.en  = 1'b1;
            next_free_d = next_free_q + FW'(1);
          end
          pfx_d    = npfx_q;
          pvalid_d = 1'b1;
          if (eot_q) begin
            pfx_d       = '0;
            pvalid_d    = 1'b0;
            next_free_d = lzwle_pkg::FIRST_FREE;
          end
          state_d = lzwle_pkg::ST_IDLE;
        end
      end
      default: state_d = lzwle_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lzwle_pkg::ST_IDLE;
      pfx_q       <= '0;
      pvalid_q    <= 1'b0;
      next_free_q <= lzwle_pkg::FIRST_FREE;
      dvld_q      <= 1'b0;
      miss_q      <= 1'b0;
      eot_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      pfx_q       <= pfx_d;
      pvalid_q    <= pvalid_d;
      next_free_q <= next_free_d;
      dvld_q      <= dvld_d;
      miss_q      <= miss_d;
      eot_q       <= eot_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    sym_q  <= sym_d;
    scan_q <= scan_d;
    npfx_q <= npfx_d;
  end

  // Output queue pointers
  always_comb begin
    cnt_d = cnt_q - {1'b0, pop};
    if (push) begin
      cnt_d = cnt_d + need;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (pop) begin
        rp_q <= ~rp_q;
      end
      if (push) begin
        wp_q <= wp_q ^ need[0];
      end
    end
  end

  // Output queue slots
  always_ff @(posedge clk_i) begin
    if (push && (need != 2'd0)) begin
      slot_q[wp_q] <= res0;
    end
    if (push && (need == 2'd2)) begin
      slot_q[~wp_q] <= res1;
    end
  end

  assign out_o.valid     = (cnt_q != 2'd0);
  assign out_o.code_out  = slot_q[rp_q].code;
  assign out_o.last_code = slot_q[rp_q].last;

endmodule

// ===== design/lzwle_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks for the letter encoder
module lzwle_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic [lzwle_pkg::LETTER_W-1:0] in_letter_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [lzwle_pkg::CODE_W-1:0]   out_code_i,
  input logic                           out_last_i
);

  // A dropped out-of-range letter leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_letter_i >= lzwle_pkg::LETTER_COUNT) |=> in_ready_i)
    else $error("block busy after a dropped letter");

  // A real letter leaves the block busy in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_letter_i < lzwle_pkg::LETTER_COUNT) |=> !in_ready_i)
    else $error("block ready right after taking a letter");

  // A stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_code_i) && $stable(out_last_i))
    else $error("stalled code item changed");

endmodule

bind lzw_letter_encoder_unit lzwle_checker u_lzwle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_letter_i (in_i.letter),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_code_i  (out_o.code_out),
  .out_last_i  (out_o.last_code)
);

// ===== verif/lzw_letter_encoder_unit_test.sv =====
`timescale 1ns / 1ps

module lzw_letter_encoder_unit_test;

  localparam int CW = lzwle_pkg::CODE_W;
  localparam int LW = lzwle_pkg::LETTER_W;

  localparam int StallLimit   = 4000;
  localparam int DrainCycles  = 120;
  localparam int LetterTarget = 1150;
  localparam int GapPercent   = 24;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lzwle_in_if  letters_if ();
  lzwle_out_if codes_if ();

  lzw_letter_encoder_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (letters_if.sink),
    .out_o  (codes_if.source)
  );

  // Encoder shadow state
  logic [CW-1:0] dict_pfx [lzwle_pkg::DICT_SIZE];
  logic [LW-1:0] dict_ltr [lzwle_pkg::DICT_SIZE];
  logic [CW-1:0] pfx_code;
  logic          pfx_live;
  int            next_code;

  lzwle_pkg::result_t pending_codes [$];
  lzwle_pkg::result_t oldest_code;
  int                 error_count;
  int                 letters_sent;
  int                 quiet_cycles;
  bit                 gaps_on;

  // Free-running clock, 2 ns period
  always begin
    #1ns clk_i = 1'b1;
    #1ns clk_i = 1'b0;
  end

  // Log one mismatch and count it
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Advance the shadow encoder by one letter and queue the codes it emits
  function automatic void encode_letter(input logic [LW-1:0] ltr, input logic eot);
    logic [CW-1:0]      hit;
    logic               found;
    int                 idx;
    lzwle_pkg::result_t code;
    if (ltr >= lzwle_pkg::LETTER_COUNT) return;
    if (!pfx_live) begin
      pfx_code = CW'(ltr) + CW'(1);
      pfx_live = 1'b1;
    end else begin
      found = 1'b0;
      hit   = '0;
      for (idx = int'(lzwle_pkg::FIRST_FREE); idx < next_code; idx++) begin
        if (!found && dict_pfx[idx] == pfx_code && dict_ltr[idx] == ltr) begin
          found = 1'b1;
          hit   = CW'(idx);
        end
      end
      if (found) begin
        pfx_code = hit;
      end else begin
        code.code = pfx_code;
        code.last = 1'b0;
        pending_codes.push_back(code);
        // Grow only while there is room
        if (next_code < lzwle_pkg::DICT_SIZE) begin
          dict_pfx[next_code] = pfx_code;
          dict_ltr[next_code] = ltr;
          next_code++;
        end
        pfx_code = CW'(ltr) + CW'(1);
      end
    end
    if (eot) begin
      code.code = pfx_code;
      code.last = 1'b1;
      pending_codes.push_back(code);
      pfx_code  = '0;
      pfx_live  = 1'b0;
      next_code = int'(lzwle_pkg::FIRST_FREE);
    end
  endfunction

  // Offer one letter; return at the falling edge after it is taken
  task automatic send_letter(input logic [LW-1:0] ltr, input logic eot);
    while (gaps_on && $urandom_range(99) < GapPercent) begin
      letters_if.valid = 1'b0;
      @(negedge clk_i);
    end
    letters_if.valid       = 1'b1;
    letters_if.letter      = ltr;
    letters_if.end_of_text = eot;
    @(posedge clk_i);
    while (!letters_if.ready) @(posedge clk_i);
    encode_letter(ltr, eot);
    @(negedge clk_i);
  endtask

  // Send one message of len letters drawn from lo..hi, with stray symbols mixed in
  task automatic send_message(input int len, input int lo, input int hi, input int noise_pct);
    int n;
    for (n = 0; n < len; n++) begin
      if ($urandom_range(99) < noise_pct)
        send_letter(LW'($urandom_range(31, 26)), 1'($urandom_range(1)));
      send_letter(LW'($urandom_range(hi, lo)), n == len - 1);
      letters_sent++;
    end
  endtask

  // Hold the sender until every queued code has come out
  task automatic wait_for_codes();
    letters_if.valid = 1'b0;
    while (pending_codes.size() != 0) @(negedge clk_i);
  endtask

  // One-letter messages at both ends of the alphabet
  task automatic test_single_letter_messages();
    send_letter(LW'(0), 1'b1);
    send_letter(LW'(25), 1'b1);
  endtask

  // Repeating patterns that hit learned entries
  task automatic test_repeated_pairs();
    send_letter(LW'(0), 1'b0);
    send_letter(LW'(1), 1'b0);
    send_letter(LW'(0), 1'b0);
    send_letter(LW'(1), 1'b0);
    send_letter(LW'(0), 1'b0);
    send_letter(LW'(1), 1'b0);
    send_letter(LW'(0), 1'b1);
    repeat (5) send_letter(LW'(25), 1'b0);
    send_letter(LW'(25), 1'b1);
  endtask

  // Symbols past Z must be dropped, end marker included
  task automatic test_ignored_letters();
    send_letter(LW'(31), 1'b1);
    send_letter(LW'(25), 1'b0);
    send_letter(LW'(26), 1'b1);
    send_letter(LW'(30), 1'b0);
    send_letter(LW'(24), 1'b1);
  endtask

  // Long messages that fill the dictionary and keep coding after it stops growing
  task automatic test_full_dictionary();
    gaps_on = 1'b0;
    send_message(200, 0, 25, 0);
    gaps_on = 1'b1;
    send_message(300, 0, 7, 3);
  endtask

  // Random messages of mixed length and alphabet, with stray symbols
  task automatic test_random_messages();
    int len;
    int lo;
    int hi;
    while (letters_sent < LetterTarget) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(60, 31) : $urandom_range(30, 1);
      if ($urandom_range(1)) begin
        lo = $urandom_range(25);
        hi = lo + $urandom_range(3);
        if (hi > 25) hi = 25;
      end else begin
        lo = 0;
        hi = 25;
      end
      send_message(len, lo, hi, 5);
      if ($urandom_range(9) == 0) wait_for_codes();
    end
  endtask

  // Drive the receiver's ready with random stalls
  always @(negedge clk_i) begin
    codes_if.ready <= !gaps_on || ($urandom_range(99) >= GapPercent);
  end

  // Compare each taken code with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && codes_if.valid && codes_if.ready) begin
      if (pending_codes.size() == 0) begin
        report_mismatch("code with none expected", int'(codes_if.code_out), 0);
      end else begin
        oldest_code = pending_codes.pop_front();
        if (codes_if.code_out !== oldest_code.code)
          report_mismatch("code_out", int'(codes_if.code_out), int'(oldest_code.code));
        if (codes_if.last_code !== oldest_code.last)
          report_mismatch("last_code", int'(codes_if.last_code), int'(oldest_code.last));
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((letters_if.valid && letters_if.ready) || (codes_if.valid && codes_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    letters_if.valid       = 1'b0;
    letters_if.letter      = '0;
    letters_if.end_of_text = 1'b0;
    codes_if.ready         = 1'b0;
    pfx_code               = '0;
    pfx_live               = 1'b0;
    next_code              = int'(lzwle_pkg::FIRST_FREE);
    error_count            = 0;
    letters_sent           = 0;
    quiet_cycles           = 0;
    gaps_on                = 1'b1;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_single_letter_messages();
    test_repeated_pairs();
    test_ignored_letters();
    test_full_dictionary();
    wait_for_codes();
    test_random_messages();

    // Drain and let the block settle
    wait_for_codes();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/lzwle_pkg.sv
design/lzwle_if.sv
design/lzwle_dict.sv
design/lzw_letter_encoder_unit.sv
design/lzwle_checker.sv
verif/lzw_letter_encoder_unit_test.sv
